/* design/bayer_demosaic_5x5_unit_macros.svh */
// Assertion macros used by the demosaic top-level design file.
`ifndef BAYER_DEMOSAIC_5X5_UNIT_MACROS_SVH
`define BAYER_DEMOSAIC_5X5_UNIT_MACROS_SVH
`define BDM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
`define BDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

/* design/bdm_pkg.sv */
// Shared types, constants and helpers of the Bayer demosaic unit.
`default_nettype none
package bdm_pkg;
   localparam int MAX_SIDE     = 2048;
   localparam int LINE_BUFFERS = 4;
   localparam int PIX_W        = 16;
   localparam int SIDE_W       = 12;
   localparam int SLOT_W       = $clog2(LINE_BUFFERS);
   localparam int ADDR_W       = $clog2(MAX_SIDE);
   localparam int SUM_W        = 21;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_SIDE = 3'd0;
   localparam logic [SIDE_W-1:0] MIN_SIDE = 12'd5;
   localparam logic [PIX_W-1:0]  PIX_MAX  = 16'hFFFF;

   typedef struct packed {
      logic produce;
      logic row_odd;
      logic col_odd;
      logic row_end;
      logic frame_end;
   } flags_type;

   typedef struct packed {
      logic [SUM_W-1:0] green_pos;
      logic [SUM_W-1:0] green_neg;
      logic [SUM_W-1:0] horiz_pos;
      logic [SUM_W-1:0] horiz_neg;
      logic [SUM_W-1:0] vert_pos;
      logic [SUM_W-1:0] vert_neg;
      logic [SUM_W-1:0] diag_pos;
      logic [SUM_W-1:0] diag_neg;
      logic [PIX_W-1:0] center;
   } sums_type;

   function automatic logic [SUM_W-1:0] ext(input logic [PIX_W-1:0] v);
      ext = {{(SUM_W-PIX_W){1'b0}}, v};
   endfunction

   function automatic logic [PIX_W-1:0] sat(input logic [SUM_W-1:0] v);
      sat = (v > ext(PIX_MAX)) ? PIX_MAX : v[PIX_W-1:0];
   endfunction
endpackage
`default_nettype wire

/* design/bdm_if.sv */
// Request and response channel interfaces of the demosaic unit.
`default_nettype none
interface bdm_req_if;
   logic                        valid;
   logic                        ready;
   logic [bdm_pkg::PIX_W-1:0]   raw_pixel;
   modport source (output valid, output raw_pixel, input ready);
   modport sink   (input valid, input raw_pixel, output ready);
endinterface

interface bdm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bdm_pkg::PIX_W-1:0]   red;
   logic [bdm_pkg::PIX_W-1:0]   green;
   logic [bdm_pkg::PIX_W-1:0]   blue;
   logic                        row_end;
   logic                        frame_end;
   modport source (output valid, output red, output green, output blue,
                   output row_end, output frame_end, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input row_end, input frame_end, output ready);
endinterface
`default_nettype wire

/* design/bdm_line_ram.sv */
// One line store bank: synchronous RAM, read-first, registered read data.
`default_nettype none
module bdm_line_ram (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [bdm_pkg::ADDR_W-1:0]  addr,
   input  wire logic [bdm_pkg::PIX_W-1:0]   wr_data,
   input  wire logic                        rd_en,
   output      logic [bdm_pkg::PIX_W-1:0]   rd_data_ff
);
   logic [bdm_pkg::PIX_W-1:0] mem [bdm_pkg::MAX_SIDE];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end
endmodule
`default_nettype wire

/* design/bdm_window.sv */
// 5x5 window registers and registered mask sums.
`default_nettype none
module bdm_window (
   input  wire logic                       clock,
   input  wire logic                       advance,
   input  wire logic                       load,
   input  wire logic [bdm_pkg::PIX_W-1:0]  col_data [4],
   input  wire logic [bdm_pkg::PIX_W-1:0]  pix,
   output      bdm_pkg::sums_type          sums_ff
);
   logic [bdm_pkg::PIX_W-1:0] win_ff [5][5];
   bdm_pkg::sums_type sums_in;
   logic [bdm_pkg::SUM_W-1:0] c, n12, n21, n23, n32, n02, n20, n24, n42;
   logic [bdm_pkg::SUM_W-1:0] n11, n13, n31, n33;

   always_ff @(posedge clock) begin
      if (advance && load) begin
         for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
         end
         for (int i = 0; i < 4; i++) begin
            win_ff[i][4] <= col_data[i];
         end
         win_ff[4][4] <= pix;
      end
      if (advance) begin
         sums_ff <= sums_in;
      end
   end

   always_comb begin
      c   = bdm_pkg::ext(win_ff[2][2]);
      n12 = bdm_pkg::ext(win_ff[1][2]);
      n21 = bdm_pkg::ext(win_ff[2][1]);
      n23 = bdm_pkg::ext(win_ff[2][3]);
      n32 = bdm_pkg::ext(win_ff[3][2]);
      n02 = bdm_pkg::ext(win_ff[0][2]);
      n20 = bdm_pkg::ext(win_ff[2][0]);
      n24 = bdm_pkg::ext(win_ff[2][4]);
      n42 = bdm_pkg::ext(win_ff[4][2]);
      n11 = bdm_pkg::ext(win_ff[1][1]);
      n13 = bdm_pkg::ext(win_ff[1][3]);
      n31 = bdm_pkg::ext(win_ff[3][1]);
      n33 = bdm_pkg::ext(win_ff[3][3]);
      sums_in.green_pos = ((n12 + n21 + n23 + n32) << 1) + (c << 2);
      sums_in.green_neg = n02 + n20 + n24 + n42;
      sums_in.horiz_pos = ((n02 + n42) >> 1) + ((n21 + n23) << 2) + (c << 2) + c;
      sums_in.horiz_neg = n11 + n13 + n20 + n24 + n31 + n33;
      sums_in.vert_pos  = ((n20 + n24) >> 1) + ((n12 + n32) << 2) + (c << 2) + c;
      sums_in.vert_neg  = n02 + n11 + n13 + n31 + n33 + n42;
      sums_in.diag_pos  = (((n11 + n13 + n31 + n33) << 1) + (c << 2) + (c << 1)) << 1;
      sums_in.diag_neg  = ((n02 + n20 + n24 + n42) << 1) + (n02 + n20 + n24 + n42);
      sums_in.center    = win_ff[2][2];
   end
endmodule
`default_nettype wire

/* design/bdm_mask_select.sv */
// Clamp mask results and pick R, G, B by Bayer phase.
`default_nettype none
module bdm_mask_select (
   input  wire bdm_pkg::sums_type          sums,
   input  wire logic                       row_odd,
   input  wire logic                       col_odd,
   output      logic [bdm_pkg::PIX_W-1:0]  red,
   output      logic [bdm_pkg::PIX_W-1:0]  green,
   output      logic [bdm_pkg::PIX_W-1:0]  blue
);
   logic [bdm_pkg::PIX_W-1:0] g_m, h_m, v_m, d_m;

   always_comb begin
      g_m = (sums.green_pos < sums.green_neg) ? '0 :
            bdm_pkg::sat((sums.green_pos - sums.green_neg) >> 3);
      h_m = (sums.horiz_pos < sums.horiz_neg) ? '0 :
            bdm_pkg::sat((sums.horiz_pos - sums.horiz_neg) >> 3);
      v_m = (sums.vert_pos < sums.vert_neg) ? '0 :
            bdm_pkg::sat((sums.vert_pos - sums.vert_neg) >> 3);
      d_m = (sums.diag_pos < sums.diag_neg) ? '0 :
            bdm_pkg::sat((sums.diag_pos - sums.diag_neg) >> 4);
      unique case ({row_odd, col_odd})
         2'b00: begin
            red = sums.center; green = g_m; blue = d_m;
         end
         2'b01: begin
            red = h_m; green = sums.center; blue = v_m;
         end
         2'b10: begin
            red = v_m; green = sums.center; blue = h_m;
         end
         default: begin
            red = d_m; green = g_m; blue = sums.center;
         end
      endcase
   end
endmodule
`default_nettype wire

/* design/bayer_demosaic_5x5_unit.sv */
// Top level of the 5x5 Bayer demosaic unit.
//  port     | dir | contents
//  req_if   | in  | raw_pixel
//  rsp_if   | out | red, green, blue, row_end, frame_end
//  csr_*    | i/o | image_side at byte address 0
// One raw pixel accepted per cycle unless rsp_if stalls; results pass s1, s2, s3 and the output register.
// Four line store banks are read at the column each cycle the pipeline advances, one bank is written.
// Stalls on rsp_if freeze the whole pipeline and drop req_if.ready.
// Reset clears counters and valid bits; line stores are never cleared.
`default_nettype none
`include "bayer_demosaic_5x5_unit_macros.svh"
module bayer_demosaic_5x5_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bdm_req_if.sink                               req_if,
   bdm_rsp_if.source                             rsp_if,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [bdm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bdm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [bdm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                             csr_pready
);
   logic [bdm_pkg::SIDE_W-1:0] side_ff, row_ff, col_ff, last_idx;
   logic [bdm_pkg::SIDE_W-1:0] row_in, col_in;
   logic [bdm_pkg::SLOT_W-1:0] slot_ff, slot_in, s1_slot_ff;
   logic advance, accept, step, side_ok, cfg_wr;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   bdm_pkg::flags_type flags_in, s1_flags_ff, s2_flags_ff, s3_flags_ff;
   logic [bdm_pkg::PIX_W-1:0] s1_pix_ff;
   logic [bdm_pkg::PIX_W-1:0] bank_rd [bdm_pkg::LINE_BUFFERS];
   logic [bdm_pkg::PIX_W-1:0] col_data [4];
   bdm_pkg::sums_type sums;
   logic [bdm_pkg::PIX_W-1:0] red_c, green_c, blue_c;
   logic [bdm_pkg::PIX_W-1:0] red_ff, green_ff, blue_ff;
   logic row_end_ff, frame_end_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(bdm_pkg::CSR_DATA_W-bdm_pkg::SIDE_W){1'b0}}, side_ff};
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr == bdm_pkg::REG_IMAGE_SIDE);

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;
   assign accept = req_if.valid && advance;
   assign side_ok = (side_ff >= bdm_pkg::MIN_SIDE)
                    && (side_ff <= bdm_pkg::SIDE_W'(bdm_pkg::MAX_SIDE))
                    && (col_ff < side_ff) && (row_ff < side_ff);
   assign step = accept && side_ok;
   assign last_idx = side_ff - 1'b1;

   always_comb begin
      flags_in.produce   = (row_ff >= 12'd4) && (col_ff >= 12'd4);
      flags_in.row_odd   = row_ff[0];
      flags_in.col_odd   = col_ff[0];
      flags_in.row_end   = (col_ff == last_idx);
      flags_in.frame_end = (col_ff == last_idx) && (row_ff == last_idx);
      row_in  = row_ff;
      col_in  = col_ff + 1'b1;
      slot_in = slot_ff;
      if (col_ff == last_idx) begin
         col_in = '0;
         if (row_ff == last_idx) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = row_ff + 1'b1;
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         slot_ff <= '0;
      end else if (cfg_wr) begin
         side_ff <= csr_pwdata[bdm_pkg::SIDE_W-1:0];
         row_ff <= '0;
         col_ff <= '0;
         slot_ff <= '0;
      end else if (step) begin
         row_ff <= row_in;
         col_ff <= col_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= step;
         s2_valid_ff <= s1_valid_ff && s1_flags_ff.produce;
         s3_valid_ff <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flags_ff <= flags_in;
         s1_pix_ff <= req_if.raw_pixel;
         s1_slot_ff <= slot_ff;
         s2_flags_ff <= s1_flags_ff;
         s3_flags_ff <= s2_flags_ff;
         red_ff <= red_c;
         green_ff <= green_c;
         blue_ff <= blue_c;
         row_end_ff <= s3_flags_ff.row_end;
         frame_end_ff <= s3_flags_ff.frame_end;
      end
   end

   for (genvar b = 0; b < bdm_pkg::LINE_BUFFERS; b++) begin : g_bank
      bdm_line_ram u_ram (
         .clock      (clock),
         .wr_en      (step && (slot_ff == bdm_pkg::SLOT_W'(b))),
         .addr       (col_ff[bdm_pkg::ADDR_W-1:0]),
         .wr_data    (req_if.raw_pixel),
         .rd_en      (advance),
         .rd_data_ff (bank_rd[b])
      );
   end

   for (genvar i = 0; i < 4; i++) begin : g_col
      assign col_data[i] = bank_rd[s1_slot_ff + bdm_pkg::SLOT_W'(i)];
   end

   bdm_window u_window (
      .clock    (clock),
      .advance  (advance),
      .load     (s1_valid_ff),
      .col_data (col_data),
      .pix      (s1_pix_ff),
      .sums_ff  (sums)
   );

   bdm_mask_select u_select (
      .sums    (sums),
      .row_odd (s3_flags_ff.row_odd),
      .col_odd (s3_flags_ff.col_odd),
      .red     (red_c),
      .green   (green_c),
      .blue    (blue_c)
   );

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.red       = red_ff;
   assign rsp_if.green     = green_ff;
   assign rsp_if.blue      = blue_ff;
   assign rsp_if.row_end   = row_end_ff;
   assign rsp_if.frame_end = frame_end_ff;

   `BDM_ASSERT_NOW(a_frame_row_end, clock, reset, rsp_valid_ff && frame_end_ff, row_end_ff)
   `BDM_ASSERT_NOW(a_count_range, clock, reset, side_ok, col_ff <= last_idx)
   `BDM_ASSERT_NEXT(a_cfg_clear, clock, reset, cfg_wr, (col_ff == '0) && (row_ff == '0))
endmodule
`default_nettype wire

/* test/tb_bayer_demosaic_5x5_unit.sv */
`timescale 1ns / 100ps
// Testbench of the 5x5 Bayer demosaic unit: streamed images checked against a pixel predictor.
module tb_bayer_demosaic_5x5_unit;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [bdm_pkg::PIX_W-1:0] red;
      logic [bdm_pkg::PIX_W-1:0] green;
      logic [bdm_pkg::PIX_W-1:0] blue;
      logic                      row_end;
      logic                      frame_end;
   } rgb_type;

   typedef enum int {STYLE_RANDOM, STYLE_EXTREME, STYLE_CROSS, STYLE_HOLE} pix_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [bdm_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [bdm_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [bdm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bdm_req_if req_if ();
   bdm_rsp_if rsp_if ();

   bayer_demosaic_5x5_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [bdm_pkg::PIX_W-1:0] pixel_q [$];
   rgb_type                   rgb_q [$];
   int                        errors = 0;
   int                        cycles = 0;
   int                        send_idle = 0;
   int                        recv_idle = 0;
   int                        hold_left = 0;
   int                        pixels_sent = 0;

   logic [bdm_pkg::PIX_W-1:0] line_mem [bdm_pkg::LINE_BUFFERS*bdm_pkg::MAX_SIDE];
   logic [bdm_pkg::PIX_W-1:0] win [5][5];
   int unsigned               side_now, row_now, col_now, slot_now;

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.raw_pixel = '0;
      rsp_if.ready = 1'b0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      side_now = 0;
      row_now = 0;
      col_now = 0;
      slot_now = 0;
   end

   function automatic void note_error(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic int unsigned px(input int i, input int j);
      return int'(win[i][j]);
   endfunction

   function automatic int unsigned clamp_eighth(input int unsigned pos, input int unsigned neg);
      int unsigned v;
      if (pos < neg) return 0;
      v = (pos - neg) >> 3;
      return (v > 65535) ? 65535 : v;
   endfunction

   function automatic int unsigned clamp_sixteenth(input int unsigned pos,
                                                   input int unsigned neg);
      int unsigned v;
      if (2 * pos < neg) return 0;
      v = (2 * pos - neg) >> 4;
      return (v > 65535) ? 65535 : v;
   endfunction

   function automatic int unsigned green_at_rb();
      return clamp_eighth(2 * (px(1, 2) + px(2, 1) + px(2, 3) + px(3, 2)) + 4 * px(2, 2),
                          px(0, 2) + px(2, 0) + px(2, 4) + px(4, 2));
   endfunction

   function automatic int unsigned horiz_at_green();
      return clamp_eighth(((px(0, 2) + px(4, 2)) >> 1) + 4 * (px(2, 1) + px(2, 3))
                          + 5 * px(2, 2),
                          px(1, 1) + px(1, 3) + px(2, 0) + px(2, 4) + px(3, 1) + px(3, 3));
   endfunction

   function automatic int unsigned vert_at_green();
      return clamp_eighth(((px(2, 0) + px(2, 4)) >> 1) + 4 * (px(1, 2) + px(3, 2))
                          + 5 * px(2, 2),
                          px(0, 2) + px(1, 1) + px(1, 3) + px(3, 1) + px(3, 3) + px(4, 2));
   endfunction

   function automatic int unsigned diag_cross();
      return clamp_sixteenth(2 * (px(1, 1) + px(1, 3) + px(3, 1) + px(3, 3)) + 6 * px(2, 2),
                             3 * (px(0, 2) + px(2, 0) + px(2, 4) + px(4, 2)));
   endfunction

   function automatic bit demosaic_step(input logic [bdm_pkg::PIX_W-1:0] pix,
                                        output rgb_type res);
      int unsigned r, g, b, slot;
      bit          produced;
      r = 0;
      g = 0;
      b = 0;
      produced = 1'b0;
      res = '0;
      if (side_now < 5 || side_now > bdm_pkg::MAX_SIDE || col_now >= side_now
          || row_now >= side_now)
         return 1'b0;
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
      for (int i = 0; i < 4; i++) begin
         slot = (slot_now + bdm_pkg::LINE_BUFFERS - (4 - i)) % bdm_pkg::LINE_BUFFERS;
         win[i][4] = line_mem[slot * bdm_pkg::MAX_SIDE + col_now];
      end
      win[4][4] = pix;
      line_mem[(slot_now % bdm_pkg::LINE_BUFFERS) * bdm_pkg::MAX_SIDE + col_now] = pix;
      if (row_now >= 4 && col_now >= 4) begin
         case ({((row_now - 2) % 2 == 1), ((col_now - 2) % 2 == 1)})
            2'b00: begin
               r = px(2, 2); g = green_at_rb(); b = diag_cross();
            end
            2'b01: begin
               r = horiz_at_green(); g = px(2, 2); b = vert_at_green();
            end
            2'b10: begin
               r = vert_at_green(); g = px(2, 2); b = horiz_at_green();
            end
            default: begin
               r = diag_cross(); g = green_at_rb(); b = px(2, 2);
            end
         endcase
         res.red = r[bdm_pkg::PIX_W-1:0];
         res.green = g[bdm_pkg::PIX_W-1:0];
         res.blue = b[bdm_pkg::PIX_W-1:0];
         res.row_end = (col_now == side_now - 1);
         res.frame_end = (col_now == side_now - 1) && (row_now == side_now - 1);
         produced = 1'b1;
      end
      if (col_now == side_now - 1) begin
         col_now = 0;
         if (row_now == side_now - 1) begin
            row_now = 0;
            slot_now = 0;
         end else begin
            row_now = row_now + 1;
            slot_now = (slot_now + 1) % bdm_pkg::LINE_BUFFERS;
         end
      end else begin
         col_now = col_now + 1;
      end
      return produced;
   endfunction

   always @(posedge clock) begin
      rgb_type res;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.raw_pixel <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (demosaic_step(req_if.raw_pixel, res)) rgb_q.push_back(res);
         end
         if (!req_if.valid || req_if.ready) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_if.valid <= 1'b1;
               req_if.raw_pixel <= pixel_q.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rgb_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.row_end, rsp_if.frame_end};
            if (rgb_q.size() == 0) begin
               note_error($sformatf("result with none expected: %p", got));
            end else begin
               want = rgb_q.pop_front();
               if (got !== want)
                  note_error($sformatf("expected %p, got %p", want, got));
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** bayer_demosaic_5x5_unit: FAILED **");
         $finish;
      end
   end

   task automatic set_side(input int unsigned value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= bdm_pkg::REG_IMAGE_SIDE;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      side_now = value & 12'hFFF;
      row_now = 0;
      col_now = 0;
      slot_now = 0;
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[bdm_pkg::SIDE_W-1:0] !== side_now[bdm_pkg::SIDE_W-1:0])
         note_error($sformatf("image_side read %0d, wrote %0d", csr_prdata, side_now));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic push_pixels(input int side, input int count, input pix_style_type style);
      int r, c;
      bit near;
      logic [bdm_pkg::PIX_W-1:0] p;
      for (int i = 0; i < count; i++) begin
         r = i / side;
         c = i % side;
         near = ((r > 2 ? r - 2 : 2 - r) + (c > 2 ? c - 2 : 2 - c)) <= 1;
         case (style)
            STYLE_CROSS: p = near ? bdm_pkg::PIX_MAX : '0;
            STYLE_HOLE:  p = near ? '0 : bdm_pkg::PIX_MAX;
            STYLE_EXTREME: begin
               case ($urandom_range(3))
                  0: p = '0;
                  1: p = bdm_pkg::PIX_MAX;
                  2: p = $urandom_range(255);
                  default: p = $urandom_range(65535);
               endcase
            end
            default: p = $urandom_range(65535);
         endcase
         pixel_q.push_back(p);
      end
      pixels_sent += count;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pixel_q.size() != 0 || req_if.valid || rgb_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic pick_pace();
      if (pixels_sent < 400) begin
         send_idle = 9;
         recv_idle = 76;
      end else if (pixels_sent < 800) begin
         send_idle = 76;
         recv_idle = 9;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   endtask

   initial begin
      int side, frames;
      bit pressed;
      pressed = 1'b0;
      pick_pace();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_side(0);
      push_pixels(5, 6, STYLE_RANDOM);
      drain();
      set_side(4);
      push_pixels(5, 6, STYLE_EXTREME);
      drain();
      set_side(4095);
      push_pixels(5, 6, STYLE_RANDOM);
      drain();
      set_side(2049);
      push_pixels(5, 4, STYLE_RANDOM);
      drain();
      pixels_sent = 0;

      set_side(5);
      push_pixels(5, 25, STYLE_CROSS);
      push_pixels(5, 25, STYLE_HOLE);
      push_pixels(5, 25, STYLE_EXTREME);
      drain();
      set_side(6);
      push_pixels(6, 36, STYLE_EXTREME);
      drain();

      while (pixels_sent < 1230) begin
         pick_pace();
         if (!pressed && pixels_sent > 850) begin
            pressed = 1'b1;
            set_side(20);
            @(negedge clock);
            hold_left = 400;
            push_pixels(20, 400, STYLE_RANDOM);
            drain();
            continue;
         end
         case ($urandom_range(19))
            0:             side = $urandom_range(17, 28);
            1, 2, 3, 4, 5: side = $urandom_range(10, 16);
            default:       side = $urandom_range(5, 9);
         endcase
         set_side(side);
         frames = (side > 16) ? 1 : $urandom_range(1, 2);
         for (int f = 0; f < frames; f++)
            push_pixels(side, side * side, $urandom_range(1) ? STYLE_EXTREME : STYLE_RANDOM);
         if (side <= 16 && $urandom_range(5) == 0)
            push_pixels(side, $urandom_range(side * side - 1), STYLE_RANDOM);
         drain();
      end

      set_side(130);
      push_pixels(130, 4 * 130 + 10, STYLE_EXTREME);
      drain();
      set_side(7);
      push_pixels(7, 49, STYLE_EXTREME);
      drain();

      if (errors == 0)
         $display("** bayer_demosaic_5x5_unit: PASSED **");
      else
         $display("** bayer_demosaic_5x5_unit: FAILED **");
      $finish;
   end
endmodule

/* sim.f */
+incdir+design
design/bdm_pkg.sv
design/bdm_if.sv
design/bdm_line_ram.sv
design/bdm_window.sv
design/bdm_mask_select.sv
design/bayer_demosaic_5x5_unit.sv
test/tb_bayer_demosaic_5x5_unit.sv
